>>> rtl/rpm_pkg.sv
// shared types, constants and the arctangent table of the polar measurement core
// no dependencies
`default_nettype none
package rpm_pkg;

  localparam int DW          = 32;
  localparam int PROD_W      = 64;
  localparam int CORDIC_N    = 17;
  localparam int CW          = 56;
  localparam int ZW          = 20;
  localparam int BEAR_W      = 19;
  localparam int SQRT_N      = 32;
  localparam int DIV_N       = 32;
  localparam int MIN_W       = 16;
  localparam int PADDR_W     = 3;
  localparam logic [0:0] REG_MIN_RANGE = 1'b0;
  localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;

  // words handed along with the cordic, square root and divider stages
  typedef struct packed {
    logic [PROD_W-1:0] sumsq;
    logic [PROD_W-1:0] dot;
    logic              neg;
  } cor_sb_t;

  typedef struct packed {
    logic [BEAR_W-1:0] bearing;
    logic [PROD_W-1:0] dot;
    logic              neg;
  } sqrt_sb_t;

  typedef struct packed {
    logic [DW-1:0]     range_m;
    logic [BEAR_W-1:0] bearing;
    logic              neg;
    logic              force0;
    logic              ovf;
  } div_sb_t;

  // arctangent of 2^-i in q16 radians
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] a;
    a = '0;
    case (i)
      0:  a = 20'sd51472;
      1:  a = 20'sd30386;
      2:  a = 20'sd16055;
      3:  a = 20'sd8150;
      4:  a = 20'sd4091;
      5:  a = 20'sd2047;
      6:  a = 20'sd1024;
      7:  a = 20'sd512;
      8:  a = 20'sd256;
      9:  a = 20'sd128;
      10: a = 20'sd64;
      11: a = 20'sd32;
      12: a = 20'sd16;
      13: a = 20'sd8;
      14: a = 20'sd4;
      15: a = 20'sd2;
      16: a = 20'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rpm_cordic.sv
// pipelined vectoring cordic giving the four-quadrant bearing: a fold stage, then one rotation per stage
// depends on rpm_pkg
`default_nettype none
module rpm_cordic
  import rpm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [DW-1:0] px,
  input  wire logic signed [DW-1:0] py,
  input  wire cor_sb_t              in_sb,
  output logic                      out_valid,
  output logic [BEAR_W-1:0]         bearing,
  output cor_sb_t                   out_sb
);

  logic                 vld [0:CORDIC_N];
  logic                 org [0:CORDIC_N];
  logic signed [CW-1:0] xs  [0:CORDIC_N];
  logic signed [CW-1:0] ys  [0:CORDIC_N];
  logic signed [ZW-1:0] zs  [0:CORDIC_N];
  cor_sb_t              sb  [0:CORDIC_N];

  logic signed [CW-1:0] x_ext, y_ext;

  // scale by 2^20 and fold the left half plane over by pi
  assign x_ext = {{(CW-DW-20){px[DW-1]}}, px, 20'b0};
  assign y_ext = {{(CW-DW-20){py[DW-1]}}, py, 20'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      org[0] <= (px == '0) && (py == '0);
      sb[0]  <= in_sb;
      if (px[DW-1]) begin
        xs[0] <= -x_ext;
        ys[0] <= -y_ext;
        zs[0] <= py[DW-1] ? -PI_Q16 : PI_Q16;
      end else begin
        xs[0] <= x_ext;
        ys[0] <= y_ext;
        zs[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 1; i <= CORDIC_N; i++) begin : g_rot
    logic signed [CW-1:0] xsh, ysh, xn, yn;
    logic signed [ZW-1:0] zn;

    always_comb begin
      xsh = xs[i-1] >>> (i-1);
      ysh = ys[i-1] >>> (i-1);
      if (!ys[i-1][CW-1]) begin
        xn = xs[i-1] + ysh;
        yn = ys[i-1] - xsh;
        zn = zs[i-1] + atan_step(i-1);
      end else begin
        xn = xs[i-1] - ysh;
        yn = ys[i-1] + xsh;
        zn = zs[i-1] - atan_step(i-1);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i]  <= xn;
        ys[i]  <= yn;
        zs[i]  <= zn;
        org[i] <= org[i-1];
        sb[i]  <= sb[i-1];
      end
    end
  end

  // clamp the residue to plus or minus pi, zero at the origin
  logic signed [ZW-1:0] zc;
  always_comb begin
    if (zs[CORDIC_N] > PI_Q16) begin
      zc = PI_Q16;
    end else if (zs[CORDIC_N] < -PI_Q16) begin
      zc = -PI_Q16;
    end else begin
      zc = zs[CORDIC_N];
    end
  end

  assign bearing   = org[CORDIC_N] ? '0 : zc[BEAR_W-1:0];
  assign out_valid = vld[CORDIC_N];
  assign out_sb    = sb[CORDIC_N];

endmodule
`default_nettype wire

>>> rtl/rpm_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on rpm_pkg
`default_nettype none
module rpm_sqrt
  import rpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [PROD_W-1:0] radicand,
  input  wire sqrt_sb_t          in_sb,
  output logic                   out_valid,
  output logic [DW-1:0]          root,
  output sqrt_sb_t               out_sb
);

  localparam int REM_W = DW + 3;

  logic              vld  [0:SQRT_N-1];
  logic [REM_W-1:0]  rem  [0:SQRT_N-1];
  logic [DW-1:0]     rt   [0:SQRT_N-1];
  logic [PROD_W-1:0] num  [0:SQRT_N-1];
  sqrt_sb_t          sb   [0:SQRT_N-1];

  for (genvar k = 0; k < SQRT_N; k++) begin : g_step
    localparam int J = SQRT_N - 1 - k;
    logic              p_vld;
    logic [REM_W-1:0]  p_rem;
    logic [DW-1:0]     p_rt;
    logic [PROD_W-1:0] p_num;
    sqrt_sb_t          p_sb;
    logic [REM_W-1:0]  cur, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rem = '0;
      assign p_rt  = '0;
      assign p_num = radicand;
      assign p_sb  = in_sb;
    end else begin : g_next
      assign p_vld = vld[k-1];
      assign p_rem = rem[k-1];
      assign p_rt  = rt[k-1];
      assign p_num = num[k-1];
      assign p_sb  = sb[k-1];
    end

    // bring down the next two bits and try the next root bit
    always_comb begin
      cur   = {p_rem[REM_W-3:0], p_num[2*J+1 -: 2]};
      trial = {1'b0, p_rt, 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? cur - trial : cur;
        rt[k]  <= {p_rt[DW-2:0], ge};
        num[k] <= p_num;
        sb[k]  <= p_sb;
      end
    end
  end

  assign out_valid = vld[SQRT_N-1];
  assign root      = rt[SQRT_N-1];
  assign out_sb    = sb[SQRT_N-1];

endmodule
`default_nettype wire

>>> rtl/rpm_div.sv
// pipelined restoring divider for the low 32 quotient bits, one bit per stage
// depends on rpm_pkg
`default_nettype none
module rpm_div
  import rpm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] num_hi,
  input  wire logic [DW-1:0] num_lo,
  input  wire logic [DW-1:0] den,
  input  wire div_sb_t       in_sb,
  output logic               out_valid,
  output logic [DW-1:0]      quot,
  output div_sb_t            out_sb
);

  logic          vld [0:DIV_N-1];
  logic [DW-1:0] rem [0:DIV_N-1];
  logic [DW-1:0] lo  [0:DIV_N-1];
  logic [DW-1:0] q   [0:DIV_N-1];
  logic [DW-1:0] dv  [0:DIV_N-1];
  div_sb_t       sb  [0:DIV_N-1];

  for (genvar k = 0; k < DIV_N; k++) begin : g_step
    logic          p_vld;
    logic [DW-1:0] p_rem, p_lo, p_q, p_dv;
    div_sb_t       p_sb;
    logic [DW:0]   cur, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rem = num_hi;
      assign p_lo  = num_lo;
      assign p_q   = '0;
      assign p_dv  = den;
      assign p_sb  = in_sb;
    end else begin : g_next
      assign p_vld = vld[k-1];
      assign p_rem = rem[k-1];
      assign p_lo  = lo[k-1];
      assign p_q   = q[k-1];
      assign p_dv  = dv[k-1];
      assign p_sb  = sb[k-1];
    end

    // shift in the next dividend bit and subtract where it fits
    always_comb begin
      cur  = {p_rem, p_lo[DW-1]};
      diff = cur - {1'b0, p_dv};
      ge   = cur >= {1'b0, p_dv};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        lo[k]  <= {p_lo[DW-2:0], 1'b0};
        q[k]   <= {p_q[DW-2:0], ge};
        dv[k]  <= p_dv;
        sb[k]  <= p_sb;
      end
    end
  end

  assign out_valid = vld[DIV_N-1];
  assign quot      = q[DIV_N-1];
  assign out_sb    = sb[DIV_N-1];

endmodule
`default_nettype wire

>>> rtl/radar_polar_measurement_core.sv
// Cartesian-to-polar radar measurement core: range, bearing and range rate per target state.
// Input channel: in_valid / in_stall with pos_x, pos_y, vel_x, vel_y (signed Q15.16).
// Output channel: out_valid / out_stall with range_m (Q16.16), bearing (Q16 rad), range_rate.
// A word is taken at a clock edge where valid is high and stall is low.
// Throughput is one word per cycle while out_stall is not holding an output word.
// The stages are: magnitude capture, four 32x32 products, 18 cordic stages (bearing),
// 32 square root stages (range), a compare stage against min_range, 32 divider stages
// (range rate) and the output register; the one-bit-per-stage root and quotient set the depth.
// When the receiver stalls a held output word, every stage freezes and in_stall is raised,
// so nothing is dropped or repeated; bubbles are not squeezed out while the stall lasts.
// Synchronous reset empties every stage and sets min_range to 0. min_range is written through
// the APB-style port at byte address 0; the user must write it only while the core is idle,
// which the core itself does not enforce. range_rate is 0 where range_m <= min_range, and
// saturates to 32 bits signed. Depends on rpm_pkg, rpm_cordic, rpm_sqrt and rpm_div.
`default_nettype none
module radar_polar_measurement_core
  import rpm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [DW-1:0] pos_x,
  input  wire logic signed [DW-1:0] pos_y,
  input  wire logic signed [DW-1:0] vel_x,
  input  wire logic signed [DW-1:0] vel_y,
  // output words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [DW-1:0]             range_m,
  output logic signed [BEAR_W-1:0]  bearing,
  output logic signed [DW-1:0]      range_rate
);

  logic en;
  logic [MIN_W-1:0] min_range;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MIN_RANGE)) begin
      min_range <= pwdata[MIN_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_MIN_RANGE) ? {{(32-MIN_W){1'b0}}, min_range} : '0;

  // stage 1: magnitudes and signs
  logic          s1_vld;
  logic [DW-1:0] s1_mpx, s1_mpy, s1_mvx, s1_mvy;
  logic signed [DW-1:0] s1_px, s1_py;
  logic          s1_n1, s1_n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= pos_x;
      s1_py  <= pos_y;
      s1_mpx <= pos_x[DW-1] ? DW'(-pos_x) : pos_x;
      s1_mpy <= pos_y[DW-1] ? DW'(-pos_y) : pos_y;
      s1_mvx <= vel_x[DW-1] ? DW'(-vel_x) : vel_x;
      s1_mvy <= vel_y[DW-1] ? DW'(-vel_y) : vel_y;
      s1_n1  <= pos_x[DW-1] ^ vel_x[DW-1];
      s1_n2  <= pos_y[DW-1] ^ vel_y[DW-1];
    end
  end

  // stage 2: squares and dot-product terms
  logic              s2_vld;
  logic [PROD_W-1:0] s2_sx, s2_sy, s2_m1, s2_m2;
  logic signed [DW-1:0] s2_px, s2_py;
  logic              s2_n1, s2_n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_sx <= s1_mpx * s1_mpx;
      s2_sy <= s1_mpy * s1_mpy;
      s2_m1 <= s1_mpx * s1_mvx;
      s2_m2 <= s1_mpy * s1_mvy;
      s2_n1 <= s1_n1;
      s2_n2 <= s1_n2;
    end
  end

  // sum of squares and signed dot product in sign-magnitude form
  cor_sb_t cor_in;
  logic    n1, n2;
  always_comb begin
    n1           = s2_n1 && (s2_m1 != '0);
    n2           = s2_n2 && (s2_m2 != '0);
    cor_in.sumsq = s2_sx + s2_sy;
    if (n1 == n2) begin
      cor_in.dot = s2_m1 + s2_m2;
      cor_in.neg = n1;
    end else if (s2_m1 >= s2_m2) begin
      cor_in.dot = s2_m1 - s2_m2;
      cor_in.neg = n1;
    end else begin
      cor_in.dot = s2_m2 - s2_m1;
      cor_in.neg = n2;
    end
  end

  // bearing
  logic              cor_vld;
  logic [BEAR_W-1:0] cor_bear;
  cor_sb_t           cor_out;

  rpm_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_vld),
    .px        (s2_px),
    .py        (s2_py),
    .in_sb     (cor_in),
    .out_valid (cor_vld),
    .bearing   (cor_bear),
    .out_sb    (cor_out)
  );

  // range
  sqrt_sb_t      sq_in, sq_out;
  logic          sq_vld;
  logic [DW-1:0] sq_root;

  assign sq_in.bearing = cor_bear;
  assign sq_in.dot     = cor_out.dot;
  assign sq_in.neg     = cor_out.neg;

  rpm_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cor_vld),
    .radicand  (cor_out.sumsq),
    .in_sb     (sq_in),
    .out_valid (sq_vld),
    .root      (sq_root),
    .out_sb    (sq_out)
  );

  // compare stage: minimum range and quotient overflow
  logic          pr_vld;
  logic [DW-1:0] pr_hi, pr_lo;
  div_sb_t       pr_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_vld <= 1'b0;
    end else if (en) begin
      pr_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_hi         <= sq_out.dot[PROD_W-1:DW];
      pr_lo         <= sq_out.dot[DW-1:0];
      pr_sb.range_m <= sq_root;
      pr_sb.bearing <= sq_out.bearing;
      pr_sb.neg     <= sq_out.neg;
      pr_sb.force0  <= !(sq_root > {{(DW-MIN_W){1'b0}}, min_range});
      pr_sb.ovf     <= sq_out.dot[PROD_W-1:DW] >= sq_root;
    end
  end

  // range rate
  logic          dv_vld;
  logic [DW-1:0] dv_q;
  div_sb_t       dv_sb;

  rpm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pr_vld),
    .num_hi    (pr_hi),
    .num_lo    (pr_lo),
    .den       (pr_sb.range_m),
    .in_sb     (pr_sb),
    .out_valid (dv_vld),
    .quot      (dv_q),
    .out_sb    (dv_sb)
  );

  // saturation and sign
  logic [DW-1:0] rate;
  always_comb begin
    if (dv_sb.force0) begin
      rate = '0;
    end else if (dv_sb.neg) begin
      if (dv_sb.ovf || (dv_q > {1'b1, {(DW-1){1'b0}}})) begin
        rate = {1'b1, {(DW-1){1'b0}}};
      end else begin
        rate = DW'(-dv_q);
      end
    end else begin
      if (dv_sb.ovf || dv_q[DW-1]) begin
        rate = {1'b0, {(DW-1){1'b1}}};
      end else begin
        rate = dv_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_m    <= dv_sb.range_m;
      bearing    <= dv_sb.bearing;
      range_rate <= rate;
    end
  end

`ifndef SYNTHESIS
  // a zero range can only come from the origin
  a_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && (range_m == '0) |-> (bearing == '0) && (range_rate == '0))
    else $error("origin word with nonzero bearing or rate");

  a_bear_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bearing <= BEAR_W'(PI_Q16)) && (bearing >= -BEAR_W'(PI_Q16)))
    else $error("bearing outside plus or minus pi");

  a_min_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid && (range_m <= {{(DW-MIN_W){1'b0}}, min_range}) |-> (range_rate == '0))
    else $error("range rate not forced to zero at small range");

  a_rst_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output word present straight after reset");
`endif

endmodule
`default_nettype wire
